>>> hw/rtl/lru_pkg.sv
// Shared constants and helpers for the LRU page replacement unit.
`default_nettype none

package lru_pkg;

  localparam int FRAMES_DEF = 8;
  localparam int PAGE_W     = 16;
  localparam int CNT32_W    = 32;
  localparam int FIDX_W     = 3;
  localparam int CFG_W      = 4;
  localparam int OUT_RAW_W  = 1 + FIDX_W + 1 + PAGE_W + CNT32_W + CNT32_W;
  localparam int OUT_W      = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int IN_W       = ((PAGE_W + 7) / 8) * 8;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

  function automatic logic [CNT32_W-1:0] sat_inc(input logic [CNT32_W-1:0] v);
    sat_inc = (v == '1) ? v : v + CNT32_W'(1);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lru_page_replacement_unit.sv
// Top level of the LRU page replacement unit with its frame table and scan sequencer.
`default_nettype none

// One page reference is taken per beat and produces exactly one result beat. A
// reference is accepted in the idle state; a single page comparator and a single
// 32-bit stamp comparator then walk the active frames from index 0 upward, and a
// write state updates the table and loads the result register once the output
// register is free. A hit ends the walk at the matching frame. The input is not
// ready while a reference is in progress; a finished result waits in the output
// register while the next reference is accepted. The frame count register may be
// written at any time the unit is idle and always accepts. No clearing pass
// follows reset.
module lru_page_replacement_unit
  import lru_pkg::*;
#(
  parameter int FRAMES = FRAMES_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [CFG_W-1:0] cfg_data_i,   // frames_in_use
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [IN_W-1:0]  s_axis_tdata, // page_number
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // hit, frame_index, evicted_valid, evicted_page, faults_so_far, hits_so_far, zero fill
  output logic [OUT_W-1:0]      m_axis_tdata
);

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam int PAD_W = OUT_W - OUT_RAW_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_e;

  state_e               state_q;
  logic [CFG_W-1:0]     cfg_q;
  logic [PAGE_W-1:0]    page_q;
  logic [CNT_W-1:0]     idx_q;
  logic [IDX_W-1:0]     slot_q;
  logic                 hit_q;
  logic [CNT32_W-1:0]   best_stamp_q;
  logic                 best_valid_q;
  logic [PAGE_W-1:0]    best_page_q;
  logic [CNT32_W-1:0]   time_q;
  logic [CNT32_W-1:0]   fault_q;
  logic [CNT32_W-1:0]   hitcnt_q;
  logic [FRAMES-1:0]    valid_q;

  logic                 out_valid_q;
  logic                 out_hit_q;
  logic [FIDX_W-1:0]    out_fidx_q;
  logic                 out_evv_q;
  logic [PAGE_W-1:0]    out_evp_q;
  logic [CNT32_W-1:0]   out_faults_q;
  logic [CNT32_W-1:0]   out_hits_q;

  logic [PAGE_W-1:0]    frame_page  [FRAMES];
  logic [CNT32_W-1:0]   frame_stamp [FRAMES];

  logic [CNT_W-1:0]     active_n;
  logic [IDX_W-1:0]     rd_idx;
  logic                 cur_valid;
  logic [PAGE_W-1:0]    cur_page;
  logic [CNT32_W-1:0]   cur_stamp;
  logic                 cur_match;
  logic                 cur_less;
  logic                 last_frame;
  logic                 out_free;
  logic                 wr_en;
  logic [CFG_W:0]       cfg_ext;

  always_comb begin
    cfg_ext = {1'b0, cfg_q};
    if (cfg_q == '0) begin
      active_n = CNT_W'(1);
    end else if (cfg_ext > (CFG_W+1)'(FRAMES)) begin
      active_n = CNT_W'(FRAMES);
    end else begin
      active_n = CNT_W'(cfg_q);
    end
  end

  assign rd_idx     = idx_q[IDX_W-1:0];
  assign cur_valid  = valid_q[rd_idx];
  assign cur_page   = frame_page[rd_idx];
  assign cur_stamp  = cur_valid ? frame_stamp[rd_idx] : '0;
  assign cur_match  = cur_valid && (cur_page == page_q);
  assign cur_less   = (idx_q == '0) || (cur_stamp < best_stamp_q);
  assign last_frame = (idx_q == (active_n - CNT_W'(1)));
  assign out_free   = !out_valid_q || m_axis_tready;
  assign wr_en      = (state_q == ST_WRITE) && out_free;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_hits_q, out_faults_q, out_evp_q, out_evv_q,
                          out_fidx_q, out_hit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cfg_q        <= CFG_RESET;
      page_q       <= '0;
      idx_q        <= '0;
      slot_q       <= '0;
      hit_q        <= 1'b0;
      best_stamp_q <= '0;
      best_valid_q <= 1'b0;
      best_page_q  <= '0;
      time_q       <= '0;
      fault_q      <= '0;
      hitcnt_q     <= '0;
      valid_q      <= '0;
      out_valid_q  <= 1'b0;
      out_hit_q    <= 1'b0;
      out_fidx_q   <= '0;
      out_evv_q    <= 1'b0;
      out_evp_q    <= '0;
      out_faults_q <= '0;
      out_hits_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        cfg_q <= cfg_data_i;
      end
      if (out_valid_q && m_axis_tready && !wr_en) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            page_q  <= s_axis_tdata[PAGE_W-1:0];
            time_q  <= sat_inc(time_q);
            idx_q   <= '0;
            hit_q   <= 1'b0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cur_match) begin
            slot_q  <= rd_idx;
            hit_q   <= 1'b1;
            state_q <= ST_WRITE;
          end else begin
            if (cur_less) begin
              best_stamp_q <= cur_stamp;
              best_valid_q <= cur_valid;
              best_page_q  <= cur_page;
              slot_q       <= rd_idx;
            end
            if (last_frame) begin
              state_q <= ST_WRITE;
            end else begin
              idx_q <= idx_q + CNT_W'(1);
            end
          end
        end
        ST_WRITE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_hit_q   <= hit_q;
            out_fidx_q  <= FIDX_W'(slot_q);
            if (hit_q) begin
              hitcnt_q     <= sat_inc(hitcnt_q);
              out_hits_q   <= sat_inc(hitcnt_q);
              out_faults_q <= fault_q;
              out_evv_q    <= 1'b0;
              out_evp_q    <= '0;
            end else begin
              fault_q         <= sat_inc(fault_q);
              out_faults_q    <= sat_inc(fault_q);
              out_hits_q      <= hitcnt_q;
              out_evv_q       <= best_valid_q;
              out_evp_q       <= best_valid_q ? best_page_q : '0;
              valid_q[slot_q] <= 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      frame_stamp[slot_q] <= time_q;
      if (!hit_q) begin
        frame_page[slot_q] <= page_q;
      end
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready right after a reference was accepted");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0]) |-> !m_axis_tdata[4])
    else $error("hit result reports an evicted page");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (idx_q < active_n))
    else $error("scan index beyond active frames");

  a_faults_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> (fault_q >= $past(fault_q)) && (hitcnt_q >= $past(hitcnt_q)))
    else $error("running counts decreased");

  a_one_count_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && !hit_q && (fault_q != '1)) |=> (hitcnt_q == $past(hitcnt_q)))
    else $error("hit count changed on a fault");
`endif

endmodule

`default_nettype wire
